// ===== sv/inode_free_list_table_top_assert.svh =====
// Assertion macros shared by the inode free list table RTL.
`ifndef INODE_FREE_LIST_TABLE_TOP_ASSERT_SVH
`define INODE_FREE_LIST_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define IFL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define IFL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ifl_pkg.sv =====
// Shared constants, control word and flag types of the inode free list table.
package ifl_pkg;

  localparam int INODE_ENTRIES = 1024;
  localparam int BLOCK_PTRS = 8;
  localparam int WORDS_PER_ENTRY = 2 + BLOCK_PTRS;
  localparam int MEM_DEPTH = INODE_ENTRIES * WORDS_PER_ENTRY;
  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int WORD_W = $clog2(WORDS_PER_ENTRY);
  localparam int CNT_W = (BLOCK_PTRS > 1) ? $clog2(BLOCK_PTRS) : 1;
  localparam int IDX_W = 10;
  localparam int WIDX_W = 4;
  localparam int HEAD_W = 11;
  localparam int DATA_W = 32;
  localparam int ATYPE_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int HEAD_REACH = 1024;
  localparam int BOUND_CAP = (INODE_ENTRIES > 2047) ? 2047 : INODE_ENTRIES;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NO_FREE   = 2'd2
  } status_t;

  typedef logic [4:0] step_t;

  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_RD_CHK   = 5'd1;
  localparam step_t S_RD_GO    = 5'd2;
  localparam step_t S_RD_OUT   = 5'd3;
  localparam step_t S_WR_CHK   = 5'd4;
  localparam step_t S_WR_DO    = 5'd5;
  localparam step_t S_AL_CHK   = 5'd6;
  localparam step_t S_AL_RD    = 5'd7;
  localparam step_t S_AL_LINK  = 5'd8;
  localparam step_t S_AL_TYPE  = 5'd9;
  localparam step_t S_AL_PTR   = 5'd10;
  localparam step_t S_AL_POP   = 5'd11;
  localparam step_t S_FR_CHK   = 5'd12;
  localparam step_t S_FR_TYPE  = 5'd13;
  localparam step_t S_FR_SIZE  = 5'd14;
  localparam step_t S_FR_LINK  = 5'd15;
  localparam step_t S_ERR_IDX  = 5'd16;
  localparam step_t S_ERR_LIST = 5'd17;

  typedef enum logic [2:0] {
    J_NONE     = 3'd0,
    J_ALWAYS   = 3'd1,
    J_DISPATCH = 3'd2,
    J_BAD_IDX  = 3'd3,
    J_BAD_FIDX = 3'd4,
    J_BAD_HEAD = 3'd5,
    J_BAD_LINK = 3'd6,
    J_CNT_MORE = 3'd7
  } jmp_t;

  typedef enum logic {
    E_REQ  = 1'b0,
    E_HEAD = 1'b1
  } ent_t;

  typedef enum logic [2:0] {
    W_REQ  = 3'd0,
    W_TYPE = 3'd1,
    W_SIZE = 3'd2,
    W_PTR0 = 3'd3,
    W_PTRK = 3'd4
  } wsel_t;

  typedef enum logic [2:0] {
    D_VALUE = 3'd0,
    D_ATYPE = 3'd1,
    D_FTYPE = 3'd2,
    D_ZERO  = 3'd3,
    D_HEAD  = 3'd4,
    D_ONES  = 3'd5
  } wd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_CNT_CLR   = 3'd1,
    ACT_CNT_INC   = 3'd2,
    ACT_LINK      = 3'd3,
    ACT_HEAD_LINK = 3'd4,
    ACT_HEAD_IDX  = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    F_NONE     = 2'd0,
    F_OK       = 2'd1,
    F_ERR_IDX  = 2'd2,
    F_ERR_LIST = 2'd3
  } fin_t;

  typedef struct packed {
    jmp_t  jmp;
    step_t tgt;
    logic  mem_rd;
    logic  mem_wr;
    ent_t  ent;
    wsel_t wsel;
    wd_t   wd;
    act_t  act;
    fin_t  fin;
    logic  out_rd;
    logic  out_alloc;
    logic  en;
  } ctl_t;

  typedef struct packed {
    logic bad_idx;
    logic bad_fidx;
    logic bad_head;
    logic bad_link;
    logic cnt_more;
  } flags_t;

endpackage

// ===== sv/ifl_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
`include "inode_free_list_table_top_assert.svh"

module ifl_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ifl_pkg::req_t   req,
  input  logic            out_free,
  input  ifl_pkg::flags_t flags,
  output ifl_pkg::ctl_t   ctl,
  output logic            idle
);
  import ifl_pkg::*;

  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '0;
    case (s)
      S_IDLE: begin
        c.jmp = J_DISPATCH;
      end
      S_RD_CHK: begin
        c.jmp = J_BAD_IDX;
        c.tgt = S_ERR_IDX;
      end
      S_RD_GO: begin
        c.mem_rd = 1'b1;
        c.ent = E_REQ;
        c.wsel = W_REQ;
      end
      S_RD_OUT: begin
        c.fin = F_OK;
        c.out_rd = 1'b1;
      end
      S_WR_CHK: begin
        c.jmp = J_BAD_IDX;
        c.tgt = S_ERR_IDX;
      end
      S_WR_DO: begin
        c.mem_wr = 1'b1;
        c.ent = E_REQ;
        c.wsel = W_REQ;
        c.wd = D_VALUE;
        c.fin = F_OK;
      end
      S_AL_CHK: begin
        c.jmp = J_BAD_HEAD;
        c.tgt = S_ERR_LIST;
      end
      S_AL_RD: begin
        c.mem_rd = 1'b1;
        c.ent = E_HEAD;
        c.wsel = W_PTR0;
      end
      S_AL_LINK: begin
        c.jmp = J_BAD_LINK;
        c.tgt = S_ERR_LIST;
        c.act = ACT_LINK;
      end
      S_AL_TYPE: begin
        c.mem_wr = 1'b1;
        c.ent = E_HEAD;
        c.wsel = W_TYPE;
        c.wd = D_ATYPE;
        c.act = ACT_CNT_CLR;
      end
      S_AL_PTR: begin
        c.jmp = J_CNT_MORE;
        c.tgt = S_AL_PTR;
        c.mem_wr = 1'b1;
        c.ent = E_HEAD;
        c.wsel = W_PTRK;
        c.wd = D_ONES;
        c.act = ACT_CNT_INC;
      end
      S_AL_POP: begin
        c.act = ACT_HEAD_LINK;
        c.fin = F_OK;
        c.out_alloc = 1'b1;
      end
      S_FR_CHK: begin
        c.jmp = J_BAD_FIDX;
        c.tgt = S_ERR_IDX;
      end
      S_FR_TYPE: begin
        c.mem_wr = 1'b1;
        c.ent = E_REQ;
        c.wsel = W_TYPE;
        c.wd = D_FTYPE;
      end
      S_FR_SIZE: begin
        c.mem_wr = 1'b1;
        c.ent = E_REQ;
        c.wsel = W_SIZE;
        c.wd = D_ZERO;
      end
      S_FR_LINK: begin
        c.mem_wr = 1'b1;
        c.ent = E_REQ;
        c.wsel = W_PTR0;
        c.wd = D_HEAD;
        c.act = ACT_HEAD_IDX;
        c.fin = F_OK;
      end
      S_ERR_IDX: begin
        c.fin = F_ERR_IDX;
      end
      S_ERR_LIST: begin
        c.fin = F_ERR_LIST;
      end
      default: begin
        c.jmp = J_ALWAYS;
        c.tgt = S_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic step_t entry(req_t r);
    step_t s;
    unique case (r)
      REQ_READ:  s = S_RD_CHK;
      REQ_WRITE: s = S_WR_CHK;
      REQ_ALLOC: s = S_AL_CHK;
      REQ_FREE:  s = S_FR_CHK;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

  step_t pc;
  step_t pc_next;
  ctl_t  word;
  logic  taken;
  logic  hold;

  always_comb begin
    word = ucode(pc);
    hold = (word.fin != F_NONE) && !out_free;
    unique case (word.jmp)
      J_NONE:     taken = 1'b0;
      J_ALWAYS:   taken = 1'b1;
      J_DISPATCH: taken = start;
      J_BAD_IDX:  taken = flags.bad_idx;
      J_BAD_FIDX: taken = flags.bad_fidx;
      J_BAD_HEAD: taken = flags.bad_head;
      J_BAD_LINK: taken = flags.bad_link;
      J_CNT_MORE: taken = flags.cnt_more;
      default:    taken = 1'b0;
    endcase
    if (hold) begin
      pc_next = pc;
    end else if (word.fin != F_NONE) begin
      pc_next = S_IDLE;
    end else if (word.jmp == J_DISPATCH) begin
      pc_next = taken ? entry(req) : S_IDLE;
    end else if (taken) begin
      pc_next = word.tgt;
    end else begin
      pc_next = pc + 5'd1;
    end
    ctl = word;
    ctl.en = !hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign idle = (pc == S_IDLE);

  `IFL_ASSERT_NEXT(a_dispatch_entry, start && idle, pc == S_RD_CHK || pc == S_WR_CHK || pc == S_AL_CHK || pc == S_FR_CHK, "Dispatch did not land on a request entry step.")
  `IFL_ASSERT_NEXT(a_hold_step, hold, $stable(pc), "Step counter moved while the result was held.")

endmodule

// ===== sv/ifl_dp.sv =====
// Datapath: entry word memory, free list head, configuration and request registers.
`include "inode_free_list_table_top_assert.svh"

module ifl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ifl_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                start,
  input  logic [ifl_pkg::IDX_W-1:0]           inode_index,
  input  logic [ifl_pkg::WIDX_W-1:0]          word_index,
  input  logic signed [ifl_pkg::DATA_W-1:0]   word_value,
  input  logic [ifl_pkg::ATYPE_W-1:0]         alloc_type,
  input  ifl_pkg::ctl_t                       ctl,
  output ifl_pkg::flags_t                     flags,
  output logic [ifl_pkg::DATA_W-1:0]          res_read,
  output logic [ifl_pkg::IDX_W-1:0]           res_alloc
);
  import ifl_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INODE_COUNT = 2'd0,
    CFG_FREE_HEAD   = 2'd1,
    CFG_FREE_TYPE   = 2'd2
  } cfg_reg_t;

  localparam logic [WORD_W-1:0] OFS_TYPE = WORD_W'(0);
  localparam logic [WORD_W-1:0] OFS_SIZE = WORD_W'(1);
  localparam logic [WORD_W-1:0] OFS_PTR0 = WORD_W'(2);

  logic [DATA_W-1:0]  mem [MEM_DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [IDX_W-1:0]   req_idx;
  logic [WIDX_W-1:0]  req_word;
  logic [DATA_W-1:0]  req_value;
  logic [ATYPE_W-1:0] req_atype;
  logic [HEAD_W-1:0]  inode_count;
  logic [CFG_W-1:0]   free_type;
  logic [HEAD_W-1:0]  free_head;
  logic [HEAD_W-1:0]  link;
  logic [CNT_W-1:0]   cnt;

  logic [HEAD_W-1:0]  bound;
  logic [IDX_W-1:0]   ent;
  logic [WORD_W-1:0]  word_ofs;
  logic [ADDR_W-1:0]  addr;
  logic [DATA_W-1:0]  wd;
  logic               link_ok;

  always_comb begin
    bound = (inode_count < HEAD_W'(BOUND_CAP)) ? inode_count : HEAD_W'(BOUND_CAP);
    ent = (ctl.ent == E_HEAD) ? free_head[IDX_W-1:0] : req_idx;
    case (ctl.wsel)
      W_REQ:   word_ofs = WORD_W'(req_word);
      W_TYPE:  word_ofs = OFS_TYPE;
      W_SIZE:  word_ofs = OFS_SIZE;
      W_PTR0:  word_ofs = OFS_PTR0;
      W_PTRK:  word_ofs = OFS_PTR0 + WORD_W'(cnt);
      default: word_ofs = OFS_TYPE;
    endcase
    addr = ADDR_W'(ent) * ADDR_W'(WORDS_PER_ENTRY) + ADDR_W'(word_ofs);
    case (ctl.wd)
      D_VALUE: wd = req_value;
      D_ATYPE: wd = DATA_W'(req_atype);
      D_FTYPE: wd = DATA_W'(free_type);
      D_ZERO:  wd = '0;
      D_HEAD:  wd = DATA_W'($signed(free_head));
      D_ONES:  wd = '1;
      default: wd = '0;
    endcase
    link_ok = (rdata == '1) ||
              ((rdata[DATA_W-1:HEAD_W] == '0) && (rdata[HEAD_W-1:0] < bound) &&
               (rdata[HEAD_W-1:0] < HEAD_W'(HEAD_REACH)));
    flags.bad_fidx = ({1'b0, req_idx} >= bound);
    flags.bad_idx = flags.bad_fidx || (32'(req_word) >= 32'(WORDS_PER_ENTRY));
    flags.bad_head = free_head[HEAD_W-1] || (free_head >= bound);
    flags.bad_link = !link_ok;
    flags.cnt_more = (cnt != CNT_W'(BLOCK_PTRS - 1));
  end

  assign res_read = rdata;
  assign res_alloc = free_head[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.mem_wr) begin
      mem[addr] <= wd;
    end
    if (ctl.en && ctl.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_idx <= inode_index;
      req_word <= word_index;
      req_value <= word_value;
      req_atype <= alloc_type;
    end
    if (ctl.en && ctl.act == ACT_LINK) begin
      link <= rdata[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inode_count <= HEAD_W'(1024);
      free_head <= '1;
      free_type <= '0;
      cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_INODE_COUNT: inode_count <= cfg_data[HEAD_W-1:0];
          CFG_FREE_HEAD:   free_head <= cfg_data[HEAD_W-1:0];
          CFG_FREE_TYPE:   free_type <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.en) begin
        unique case (ctl.act)
          ACT_CNT_CLR:   cnt <= '0;
          ACT_CNT_INC:   cnt <= cnt + CNT_W'(1);
          ACT_HEAD_LINK: free_head <= link;
          ACT_HEAD_IDX:  free_head <= HEAD_W'(req_idx);
          default: ;
        endcase
      end
    end
  end

  `IFL_ASSERT_NEXT(a_pop_loads_link, ctl.en && ctl.act == ACT_HEAD_LINK && !cfg_wr_en, free_head == $past(link), "Allocate did not move the free head to the popped link.")

endmodule

// ===== sv/inode_free_list_table_top.sv =====
// Top level of the inode free list table: sequencer, datapath and result register.
//
// Usage: one request word enters on the input channel (in_valid, in_stall)
// and gives exactly one result word on the output channel (out_valid,
// out_stall). Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_data while the block is idle; writing the initial free
// head also loads the free list head. The block itself does not enforce
// that it is idle when a configuration register is written.
// One request is in work at a time; allocate writes every block pointer
// one after another through the single-port entry memory.
// A new request is taken as soon as the sequencer returns to idle, even
// while the last result still waits in the output register.
// If the receiver stalls and the register is still full when the next
// result is ready, the sequencer holds on its final step until it drains.
// Reset clears the free list to empty and the registers to their defaults;
// the entry memory holds unknown data until written.
`include "inode_free_list_table_top_assert.svh"

module inode_free_list_table_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ifl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ifl_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ifl_pkg::req_t                     req_type,
  input  logic [ifl_pkg::IDX_W-1:0]         inode_index,
  input  logic [ifl_pkg::WIDX_W-1:0]        word_index,
  input  logic signed [ifl_pkg::DATA_W-1:0] word_value,
  input  logic [ifl_pkg::ATYPE_W-1:0]       alloc_type,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ifl_pkg::status_t                  status,
  output logic signed [ifl_pkg::DATA_W-1:0] read_value,
  output logic [ifl_pkg::IDX_W-1:0]         alloc_index
);
  import ifl_pkg::*;

  ctl_t               ctl;
  flags_t             flags;
  logic               idle;
  logic               start;
  logic               out_free;
  logic               fin_fire;
  logic [DATA_W-1:0]  res_read;
  logic [IDX_W-1:0]   res_alloc;

  assign in_stall = !idle;
  assign start = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fin_fire = ctl.en && (ctl.fin != F_NONE);

  ifl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req_type),
    .out_free (out_free),
    .flags    (flags),
    .ctl      (ctl),
    .idle     (idle)
  );

  ifl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .inode_index (inode_index),
    .word_index  (word_index),
    .word_value  (word_value),
    .alloc_type  (alloc_type),
    .ctl         (ctl),
    .flags       (flags),
    .res_read    (res_read),
    .res_alloc   (res_alloc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      unique case (ctl.fin)
        F_ERR_IDX:  status <= ST_BAD_INDEX;
        F_ERR_LIST: status <= ST_NO_FREE;
        default:    status <= ST_OK;
      endcase
      read_value <= ctl.out_rd ? res_read : '0;
      alloc_index <= ctl.out_alloc ? res_alloc : '0;
    end
  end

  `IFL_ASSERT_IMPL(a_no_overwrite, fin_fire, out_free, "A result was finished while the output register was still full.")
  `IFL_ASSERT_NEXT(a_busy_after_accept, start, in_stall, "The block took no busy state after accepting a request.")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the inode free list table: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import ifl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_TYPE = 2'd2;
  localparam int NO_LINK = -1;
  localparam int PTR0_WORD = 2;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 228;

  typedef struct {
    status_t     status;
    logic [31:0] read_value;
    logic [9:0]  alloc_index;
  } reply_t;

  typedef struct {
    req_t        req;
    logic [9:0]  idx;
    logic [3:0]  widx;
    logic [31:0] val;
    logic [15:0] atype;
    bit          typed;
    reply_t      want;
  } stim_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t req_type = REQ_READ;
  logic [IDX_W-1:0] inode_index = '0;
  logic [WIDX_W-1:0] word_index = '0;
  logic signed [DATA_W-1:0] word_value = '0;
  logic [ATYPE_W-1:0] alloc_type = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t status;
  logic signed [DATA_W-1:0] read_value;
  logic [IDX_W-1:0] alloc_index;

  logic [31:0] shadow_words [0:MEM_DEPTH-1];
  bit word_set [0:MEM_DEPTH-1];
  int list_head = NO_LINK;
  int inode_limit = INODE_ENTRIES;
  logic [15:0] shadow_ftype = '0;

  reply_t awaited_replies [$];
  stim_row_t directed_rows [$];
  int mismatches = 0;
  bit calm = 1'b0;

  inode_free_list_table_top dut (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .req_type, .inode_index, .word_index, .word_value, .alloc_type,
    .out_valid, .out_stall, .status, .read_value, .alloc_index
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : run_limit
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int entry_bound();
    return (inode_limit < INODE_ENTRIES) ? inode_limit : INODE_ENTRIES;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic stim_row_t mk_row(req_t req, int idx, int widx, logic [31:0] val,
                                       int atype, bit typed = 1'b0, status_t st = ST_OK,
                                       logic [31:0] rd = '0, int ai = 0);
    stim_row_t r;
    r.req = req;
    r.idx = 10'(idx);
    r.widx = 4'(widx);
    r.val = val;
    r.atype = 16'(atype);
    r.typed = typed;
    r.want.status = st;
    r.want.read_value = rd;
    r.want.alloc_index = 10'(ai);
    return r;
  endfunction

  // Applies one request word to the shadow table and returns the reply it must give.
  function automatic reply_t apply_request(stim_row_t r);
    reply_t rep;
    int b, base, nxt;
    rep.status = ST_OK;
    rep.read_value = '0;
    rep.alloc_index = '0;
    b = entry_bound();
    base = int'(r.idx) * WORDS_PER_ENTRY;
    case (r.req)
      REQ_READ, REQ_WRITE: begin
        if (int'(r.idx) >= b || int'(r.widx) >= WORDS_PER_ENTRY) begin
          rep.status = ST_BAD_INDEX;
        end else if (r.req == REQ_READ) begin
          rep.read_value = shadow_words[base + r.widx];
        end else begin
          shadow_words[base + r.widx] = r.val;
          word_set[base + r.widx] = 1'b1;
        end
      end
      REQ_ALLOC: begin
        if (list_head < 0 || list_head >= b) begin
          rep.status = ST_NO_FREE;
        end else begin
          base = list_head * WORDS_PER_ENTRY;
          nxt = shadow_words[base + PTR0_WORD];
          if (nxt != NO_LINK && (nxt < 0 || nxt >= b || nxt >= HEAD_REACH)) begin
            rep.status = ST_NO_FREE;
          end else begin
            rep.alloc_index = 10'(list_head);
            shadow_words[base] = {16'd0, r.atype};
            word_set[base] = 1'b1;
            for (int k = PTR0_WORD; k < WORDS_PER_ENTRY; k++) begin
              shadow_words[base + k] = '1;
              word_set[base + k] = 1'b1;
            end
            list_head = nxt;
          end
        end
      end
      default: begin
        if (int'(r.idx) >= b) begin
          rep.status = ST_BAD_INDEX;
        end else begin
          shadow_words[base] = {16'd0, shadow_ftype};
          shadow_words[base + 1] = '0;
          shadow_words[base + PTR0_WORD] = list_head;
          word_set[base] = 1'b1;
          word_set[base + 1] = 1'b1;
          word_set[base + PTR0_WORD] = 1'b1;
          list_head = int'(r.idx);
        end
      end
    endcase
    return rep;
  endfunction

  task automatic send_request(stim_row_t r);
    int gap;
    reply_t rep;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= r.req;
    inode_index <= r.idx;
    word_index <= r.widx;
    word_value <= r.val;
    alloc_type <= r.atype;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    rep = apply_request(r);
    awaited_replies.push_back(r.typed ? r.want : rep);
  endtask

  task automatic program_regs(bit set_count, int count, bit set_head, int head,
                              bit set_ftype, int ftype);
    if (set_count) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_INODE_COUNT;
      cfg_data <= 16'(count);
      @(posedge clk);
      inode_limit = count & 'h7FF;
    end
    if (set_head) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FREE_HEAD;
      cfg_data <= 16'(head);
      @(posedge clk);
      list_head = head;
    end
    if (set_ftype) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FREE_TYPE;
      cfg_data <= 16'(ftype);
      @(posedge clk);
      shadow_ftype = 16'(ftype);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : reply_monitor
    reply_t want;
    int pause;
    pause = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("result word with nothing awaited: status %0d", status);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            mismatches++;
          end
          if (alloc_index !== want.alloc_index) begin
            $error("alloc_index: expected %0d, got %0d", want.alloc_index, alloc_index);
            mismatches++;
          end
        end
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        pause--;
      end else begin
        out_stall <= 1'b0;
        if (!calm) pause = idle_len();
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int phase, n, k, b, hot, cnt, hd;
    bit set_c, set_h, set_f;

    // Reset state: full count, empty free list, free type zero.
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 0, 1, ST_NO_FREE));
    directed_rows.push_back(mk_row(REQ_READ, 0, 10, 0, 0, 1, ST_BAD_INDEX));
    directed_rows.push_back(mk_row(REQ_WRITE, 1023, 15, 32'h1234_5678, 0, 1, ST_BAD_INDEX));
    directed_rows.push_back(mk_row(REQ_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 1, ST_OK));
    directed_rows.push_back(mk_row(REQ_WRITE, 1023, 9, 32'h8000_0000, 0, 1, ST_OK));
    directed_rows.push_back(mk_row(REQ_READ, 1023, 9, 0, 0, 1, ST_OK, 32'h8000_0000));
    directed_rows.push_back(mk_row(REQ_READ, 0, 0, 0, 0, 1, ST_OK, 32'h7FFF_FFFF));
    directed_rows.push_back(mk_row(REQ_FREE, 1023, 15, 0, 0, 1, ST_OK));
    directed_rows.push_back(mk_row(REQ_FREE, 0, 0, 0, 0, 1, ST_OK));
    directed_rows.push_back(mk_row(REQ_READ, 0, 2, 0, 0));
    directed_rows.push_back(mk_row(REQ_READ, 0, 1, 0, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 16'hFFFF));
    directed_rows.push_back(mk_row(REQ_READ, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(REQ_READ, 0, 9, 0, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 0, 1, ST_NO_FREE));
    // A link past the table and a negative link other than the end marker are both refused.
    directed_rows.push_back(mk_row(REQ_FREE, 5, 3, 0, 0));
    directed_rows.push_back(mk_row(REQ_WRITE, 5, 2, 32'h0000_0400, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 16'h00A5, 1, ST_NO_FREE));
    directed_rows.push_back(mk_row(REQ_WRITE, 5, 2, 32'hFFFF_FFFE, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 16'h5A00, 1, ST_NO_FREE));
    directed_rows.push_back(mk_row(REQ_WRITE, 5, 2, 32'hFFFF_FFFF, 0));
    directed_rows.push_back(mk_row(REQ_ALLOC, 0, 0, 0, 16'h5A00));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    in_valid <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      while (awaited_replies.size() != 0) @(posedge clk);
      case (phase)
        0: program_regs(1, INODE_ENTRIES, 1, NO_LINK, 1, 16'hFFFF);
        1: program_regs(1, 1, 1, 0, 1, 0);
        2: program_regs(1, 16, 1, INODE_ENTRIES - 1, 1, $urandom_range(0, 65535));
        default: begin
          set_c = $urandom_range(0, 2) != 0;
          set_h = $urandom_range(0, 2) != 0;
          set_f = $urandom_range(0, 2) != 0;
          if (!(set_c || set_h || set_f)) set_c = 1'b1;
          case ($urandom_range(0, 3))
            0: cnt = 1;
            1: cnt = INODE_ENTRIES;
            2: cnt = $urandom_range(2, 40);
            default: cnt = $urandom_range(1, INODE_ENTRIES);
          endcase
          case ($urandom_range(0, 3))
            0: hd = NO_LINK;
            1: hd = INODE_ENTRIES - 1;
            2: hd = $urandom_range(0, (set_c ? cnt : inode_limit) - 1);
            default: hd = $urandom_range(0, INODE_ENTRIES - 1);
          endcase
          program_regs(set_c, cnt, set_h, hd, set_f, $urandom_range(0, 65535));
        end
      endcase
      calm = (phase == 0 || phase == 4);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        b = entry_bound();
        hot = (b < 24) ? b : 24;
        r = mk_row(REQ_READ, 0, 0, $urandom, $urandom_range(0, 65535));
        k = $urandom_range(0, 9);
        if (k < 7) r.idx = 10'($urandom_range(0, hot - 1));
        else if (k < 9) r.idx = 10'($urandom_range(0, b - 1));
        else r.idx = 10'($urandom_range(0, INODE_ENTRIES - 1));
        if ($urandom_range(0, 9) != 0) r.widx = 4'($urandom_range(0, WORDS_PER_ENTRY - 1));
        else r.widx = 4'($urandom_range(WORDS_PER_ENTRY, 15));
        k = $urandom_range(0, 99);
        if (k < 30) begin
          r.req = REQ_READ;
          if (int'(r.idx) < b && int'(r.widx) < WORDS_PER_ENTRY &&
              !word_set[int'(r.idx) * WORDS_PER_ENTRY + r.widx]) r.req = REQ_WRITE;
        end else if (k < 55) begin
          r.req = REQ_WRITE;
          if (r.widx == PTR0_WORD && $urandom_range(0, 1) != 0) begin
            if ($urandom_range(0, 3) == 0) r.val = '1;
            else r.val = $urandom_range(0, b - 1);
          end
        end else if (k < 77) begin
          r.req = REQ_ALLOC;
          // The head's link must hold a known word before it can be popped.
          if (list_head >= 0 && list_head < b &&
              !word_set[list_head * WORDS_PER_ENTRY + PTR0_WORD]) begin
            r.req = REQ_WRITE;
            r.idx = 10'(list_head);
            r.widx = 4'(PTR0_WORD);
            if ($urandom_range(0, 1) != 0) r.val = '1;
            else r.val = $urandom_range(0, b - 1);
          end
        end else begin
          r.req = REQ_FREE;
        end
        send_request(r);
      end
      in_valid <= 1'b0;
    end

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ifl_pkg.sv
sv/ifl_seq.sv
sv/ifl_dp.sv
sv/inode_free_list_table_top.sv
verif/tb.sv
